>>> rtl/core/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared widths, register indexes and the per-candidate gap function for the
// periodic box distance pipeline.
// ----------------------------------------------------------------------------
package bdp_pkg;

   localparam int COORD_W    = 32;  // Q16.16 signed corner
   localparam int PERIOD_W   = 31;  // Q15.16 unsigned period
   localparam int EXT_W      = 35;  // corner +/- period, then a difference
   localparam int CAND_W     = 34;  // candidate gap, before the min
   localparam int GAP_W      = 32;  // kept gap never exceeds the unshifted one
   localparam int SQ_W       = 2 * GAP_W;
   localparam int SUM_W      = SQ_W + 2;  // three squares
   localparam int ROOT_W     = SUM_W / 2;
   localparam int REM_W      = ROOT_W + 4;
   localparam int SHIFTS     = 3;   // unshifted, +period, -period
   localparam int MAX_AXES   = 3;
   localparam int AXIS_LAT   = 4;
   localparam int LATENCY    = AXIS_LAT + 1 + ROOT_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [EXT_W-1:0]  ext_type;
   typedef logic [CAND_W-1:0]        cand_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;

   localparam csr_idx_type REG_PERIOD_X = 2'd0;
   localparam csr_idx_type REG_PERIOD_Y = 2'd1;
   localparam csr_idx_type REG_PERIOD_Z = 2'd2;

   // Gap between [min0,max0] and [min1,max1]; zero on overlap. Inverted boxes
   // go through the same two compares.
   function automatic cand_type gap_of(ext_type min0, ext_type max0,
                                       ext_type min1, ext_type max1);
      ext_type diff;
      if (min0 > max1) begin
         diff = min0 - max1;
      end else if (max0 < min1) begin
         diff = min1 - max0;
      end else begin
         diff = '0;
      end
      return diff[CAND_W-1:0];
   endfunction

endpackage

>>> rtl/core/bdp_axis_gap.sv
// ----------------------------------------------------------------------------
// bdp_axis_gap
// One axis: shifted copies of box B, three candidate gaps, their minimum and
// its square. Four register stages.
// ----------------------------------------------------------------------------
module bdp_axis_gap
   import bdp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [COORD_W-1:0]  a_min,
   input  logic signed [COORD_W-1:0]  a_max,
   input  logic signed [COORD_W-1:0]  b_min,
   input  logic signed [COORD_W-1:0]  b_max,
   input  logic [PERIOD_W-1:0]        period,
   output logic                       out_valid,
   output logic [SQ_W-1:0]            out_sq
);

   ext_type  period_ext;
   ext_type  a_min_ff, a_max_ff;
   ext_type  b_min_ff [0:SHIFTS-1];
   ext_type  b_max_ff [0:SHIFTS-1];
   cand_type cand_ff  [0:SHIFTS-1];
   cand_type min_01, min_in;
   logic [GAP_W-1:0] gap_ff;
   logic [SQ_W-1:0]  sq_ff;
   logic valid_a_ff, valid_b_ff, valid_c_ff, valid_d_ff;

   assign period_ext = $signed({{(EXT_W-PERIOD_W){1'b0}}, period});

   always_comb begin
      min_01 = (cand_ff[1] < cand_ff[0]) ? cand_ff[1] : cand_ff[0];
      min_in = (cand_ff[2] < min_01) ? cand_ff[2] : min_01;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         valid_d_ff <= valid_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_min_ff    <= EXT_W'(a_min);
      a_max_ff    <= EXT_W'(a_max);
      b_min_ff[0] <= EXT_W'(b_min);
      b_max_ff[0] <= EXT_W'(b_max);
      b_min_ff[1] <= EXT_W'(b_min) + period_ext;
      b_max_ff[1] <= EXT_W'(b_max) + period_ext;
      b_min_ff[2] <= EXT_W'(b_min) - period_ext;
      b_max_ff[2] <= EXT_W'(b_max) - period_ext;
      for (int j = 0; j < SHIFTS; j++) begin
         cand_ff[j] <= gap_of(a_min_ff, a_max_ff, b_min_ff[j], b_max_ff[j]);
      end
      gap_ff <= min_in[GAP_W-1:0];
      sq_ff  <= gap_ff * gap_ff;
   end

   assign out_valid = valid_d_ff;
   assign out_sq    = sq_ff;

   // kept gap fits GAP_W bits since it never exceeds the unshifted one
   a_min_fits: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |-> (min_in[CAND_W-1:GAP_W] == '0))
      else $error("axis gap exceeds kept width");

   a_min_le_plain: assert property (@(posedge clock) disable iff (reset)
      valid_c_ff |-> (CAND_W'(gap_ff) <= $past(cand_ff[0])))
      else $error("kept gap above unshifted gap");

endmodule

>>> rtl/core/bdp_isqrt.sv
// ----------------------------------------------------------------------------
// bdp_isqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module bdp_isqrt
   import bdp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [SUM_W-1:0]   in_rad,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root
);

   localparam int LAST = ROOT_W - 1;

   logic [SUM_W-1:0]  rad_ff  [0:LAST];
   logic [REM_W-1:0]  rem_ff  [0:LAST];
   logic [ROOT_W-1:0] root_ff [0:LAST];
   logic [LAST:0]     vld_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [SUM_W-1:0]  rad_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic              vld_cur;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W:0]    diff;
      logic              take;

      if (k == 0) begin : g_first
         assign rad_cur  = in_rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign rad_cur  = rad_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign vld_cur  = vld_ff[k-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh = {rem_cur[REM_W-3:0], rad_cur[SUM_W-1 -: 2]};
      assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_cur, 2'b01};
      assign diff   = {1'b0, rem_sh} - {1'b0, trial};
      assign take   = ~diff[REM_W];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[k]  <= rad_cur << 2;
         rem_ff[k]  <= take ? diff[REM_W-1:0] : rem_sh;
         root_ff[k] <= {root_cur[ROOT_W-2:0], take};
      end
   end

   assign out_valid = vld_ff[LAST];
   assign out_root  = root_ff[LAST];

   // restoring invariant: remainder never above twice the root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |-> (rem_ff[LAST] <= REM_W'({root_ff[LAST], 1'b0})))
      else $error("square root remainder out of bound");

endmodule

>>> rtl/core/box_distance_periodic.sv
// ----------------------------------------------------------------------------
// box_distance_periodic
// Floor of the Euclidean distance between two axis-aligned boxes, with an
// optional per-axis period. Q16.16 in, Q17.16 out.
// ----------------------------------------------------------------------------
// Takes one box pair per clock: busy stays low, so a beat is accepted in every
// cycle with start high. The result appears on rsp_box_gap with rsp_valid
// high for one cycle, in order; the receiver cannot stall it. The pipeline
// has four stages per axis (shift, candidate gaps, minimum, square), one stage
// for the sum of squares and 33 stages of the square root, one root bit each.
// Period registers are written through the csr_ port, which is always ready;
// write them only when no pair is in flight. A period of zero gives the plain
// distance.
// ----------------------------------------------------------------------------
module box_distance_periodic
   import bdp_pkg::*;
#(
   parameter int AXES = 3
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_a_min_x,
   input  logic signed [COORD_W-1:0] req_a_min_y,
   input  logic signed [COORD_W-1:0] req_a_min_z,
   input  logic signed [COORD_W-1:0] req_a_max_x,
   input  logic signed [COORD_W-1:0] req_a_max_y,
   input  logic signed [COORD_W-1:0] req_a_max_z,
   input  logic signed [COORD_W-1:0] req_b_min_x,
   input  logic signed [COORD_W-1:0] req_b_min_y,
   input  logic signed [COORD_W-1:0] req_b_min_z,
   input  logic signed [COORD_W-1:0] req_b_max_x,
   input  logic signed [COORD_W-1:0] req_b_max_y,
   input  logic signed [COORD_W-1:0] req_b_max_z,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   output logic                      rsp_valid,
   output logic [ROOT_W-1:0]         rsp_box_gap
);

   logic signed [COORD_W-1:0] a_min [0:MAX_AXES-1];
   logic signed [COORD_W-1:0] a_max [0:MAX_AXES-1];
   logic signed [COORD_W-1:0] b_min [0:MAX_AXES-1];
   logic signed [COORD_W-1:0] b_max [0:MAX_AXES-1];
   logic [PERIOD_W-1:0]       period_ff [0:MAX_AXES-1];
   logic [PERIOD_W-1:0]       period_in [0:MAX_AXES-1];
   logic [SQ_W-1:0]           sq [0:AXES-1];
   logic [AXES-1:0]           ax_valid;
   logic [SUM_W-1:0]          sum_in, sum_ff;
   logic                      sum_valid_ff;
   logic                      accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   assign a_min[0] = req_a_min_x;
   assign a_min[1] = req_a_min_y;
   assign a_min[2] = req_a_min_z;
   assign a_max[0] = req_a_max_x;
   assign a_max[1] = req_a_max_y;
   assign a_max[2] = req_a_max_z;
   assign b_min[0] = req_b_min_x;
   assign b_min[1] = req_b_min_y;
   assign b_min[2] = req_b_min_z;
   assign b_max[0] = req_b_max_x;
   assign b_max[1] = req_b_max_y;
   assign b_max[2] = req_b_max_z;

   always_comb begin
      period_in = period_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PERIOD_X: period_in[0] = csr_wdata[PERIOD_W-1:0];
            REG_PERIOD_Y: period_in[1] = csr_wdata[PERIOD_W-1:0];
            REG_PERIOD_Z: period_in[2] = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_AXES; i++) begin
            period_ff[i] <= '0;
         end
      end else begin
         period_ff <= period_in;
      end
   end

   for (genvar i = 0; i < AXES; i++) begin : g_axis
      bdp_axis_gap u_axis (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (accept),
         .a_min     (a_min[i]),
         .a_max     (a_max[i]),
         .b_min     (b_min[i]),
         .b_max     (b_max[i]),
         .period    (period_ff[i]),
         .out_valid (ax_valid[i]),
         .out_sq    (sq[i])
      );
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < AXES; i++) begin
         sum_in = sum_in + SUM_W'(sq[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= &ax_valid;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   bdp_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid_ff),
      .in_rad    (sum_ff),
      .out_valid (rsp_valid),
      .out_root  (rsp_box_gap)
   );

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without matching accepted beat");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (ax_valid == '0) || (ax_valid == '1))
      else $error("axis lanes out of step");

   a_csr_ignore: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index != REG_PERIOD_X &&
       csr_index != REG_PERIOD_Y && csr_index != REG_PERIOD_Z)
      |=> (period_ff[0] == $past(period_ff[0]) &&
           period_ff[1] == $past(period_ff[1]) &&
           period_ff[2] == $past(period_ff[2])))
      else $error("write to unknown index changed a period");

endmodule

>>> test/box_distance_periodic_monitor.sv
// ----------------------------------------------------------------------------
// box_distance_periodic_monitor
// Watches the pair, register and result channels of the periodic box distance
// block. It predicts the distance of every accepted pair from its own copy of
// the period registers and checks the results in order.
// ----------------------------------------------------------------------------
module box_distance_periodic_monitor
   import bdp_pkg::*;
#(
   parameter int AXES = 3
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [COORD_W-1:0]    req_a_min_x,
   input  logic [COORD_W-1:0]    req_a_min_y,
   input  logic [COORD_W-1:0]    req_a_min_z,
   input  logic [COORD_W-1:0]    req_a_max_x,
   input  logic [COORD_W-1:0]    req_a_max_y,
   input  logic [COORD_W-1:0]    req_a_max_z,
   input  logic [COORD_W-1:0]    req_b_min_x,
   input  logic [COORD_W-1:0]    req_b_min_y,
   input  logic [COORD_W-1:0]    req_b_min_z,
   input  logic [COORD_W-1:0]    req_b_max_x,
   input  logic [COORD_W-1:0]    req_b_max_y,
   input  logic [COORD_W-1:0]    req_b_max_z,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_valid,
   input  logic [ROOT_W-1:0]     rsp_box_gap,
   output int                    errors,
   output int                    outstanding
);

   logic [MAX_AXES-1:0][COORD_W-1:0]  a_lo, a_hi, b_lo, b_hi;
   logic [MAX_AXES-1:0][PERIOD_W-1:0] period_copy;
   logic [ROOT_W-1:0]                 gap_fifo [$];

   assign a_lo = {req_a_min_z, req_a_min_y, req_a_min_x};
   assign a_hi = {req_a_max_z, req_a_max_y, req_a_max_x};
   assign b_lo = {req_b_min_z, req_b_min_y, req_b_min_x};
   assign b_hi = {req_b_max_z, req_b_max_y, req_b_max_x};

   // separation of two intervals, zero on overlap; inverted ones use the same compares
   function automatic logic [63:0] span_gap(longint lo0, longint hi0,
                                            longint lo1, longint hi1);
      if (lo0 > hi1) return 64'(lo0 - hi1);
      if (hi0 < lo1) return 64'(lo1 - hi0);
      return '0;
   endfunction

   function automatic logic [63:0] wrapped_gap(longint lo0, longint hi0,
                                               longint lo1, longint hi1,
                                               longint per);
      logic [63:0] best;
      logic [63:0] alt;
      best = span_gap(lo0, hi0, lo1, hi1);
      alt  = span_gap(lo0, hi0, lo1 + per, hi1 + per);
      if (alt < best) best = alt;
      alt  = span_gap(lo0, hi0, lo1 - per, hi1 - per);
      if (alt < best) best = alt;
      return best;
   endfunction

   function automatic logic [ROOT_W-1:0] floor_root(logic [SUM_W-1:0] sum);
      logic [ROOT_W:0]     root;
      logic [ROOT_W:0]     trial;
      logic [2*ROOT_W+1:0] trial_sq;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial    = root | ({{ROOT_W{1'b0}}, 1'b1} << b);
         trial_sq = trial * trial;
         if (trial_sq <= {2'b00, sum}) root = trial;
      end
      return root[ROOT_W-1:0];
   endfunction

   function automatic logic [ROOT_W-1:0] predict_box_gap();
      logic [SUM_W-1:0] sum;
      logic [63:0]      g;
      sum = '0;
      for (int i = 0; i < AXES && i < MAX_AXES; i++) begin
         g = wrapped_gap(longint'($signed(a_lo[i])), longint'($signed(a_hi[i])),
                         longint'($signed(b_lo[i])), longint'($signed(b_hi[i])),
                         longint'(period_copy[i]));
         sum = sum + g * g;
      end
      return floor_root(sum);
   endfunction

   always @(posedge clock) begin
      logic [ROOT_W-1:0] want;
      if (reset) begin
         gap_fifo.delete();
         period_copy <= '0;
         errors      <= 0;
         outstanding <= 0;
      end else begin
         // pop before push so a beat never meets its own expectation
         if (rsp_valid) begin
            if (gap_fifo.size() == 0) begin
               $display("%0t: unexpected result beat, box_gap %0d", $time, rsp_box_gap);
               errors <= errors + 1;
            end else begin
               want = gap_fifo.pop_front();
               if (rsp_box_gap !== want) begin
                  $display("%0t: box_gap mismatch: expected %0d actual %0d",
                           $time, want, rsp_box_gap);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy) gap_fifo.push_back(predict_box_gap());
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PERIOD_X: period_copy[0] <= csr_wdata[PERIOD_W-1:0];
               REG_PERIOD_Y: period_copy[1] <= csr_wdata[PERIOD_W-1:0];
               REG_PERIOD_Z: period_copy[2] <= csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
         outstanding <= gap_fifo.size();
      end
   end

endmodule

>>> test/box_distance_periodic_tb.sv
// ----------------------------------------------------------------------------
// box_distance_periodic_tb
// Drives box pairs and period writes into the periodic box distance block:
// directed corner cases first, then random pairs over several period settings
// and sender idle patterns. The monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module box_distance_periodic_tb;
   import bdp_pkg::*;

   localparam csr_idx_type REG_SPARE = 2'd3;  // no register behind this index
   localparam logic [31:0] CMIN = 32'h8000_0000;
   localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] HALF = 32'h0000_8000;
   localparam int          PHASE_ITEMS = 190;

   typedef logic [MAX_AXES-1:0][COORD_W-1:0] corner_type;
   typedef struct packed {
      corner_type a_lo;
      corner_type a_hi;
      corner_type b_lo;
      corner_type b_hi;
   } box_pair_type;
   typedef enum int {PAIR_NOISE, PAIR_NEAR, PAIR_PERIODIC} pair_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [COORD_W-1:0] req_a_min_x = '0, req_a_min_y = '0, req_a_min_z = '0;
   logic [COORD_W-1:0] req_a_max_x = '0, req_a_max_y = '0, req_a_max_z = '0;
   logic [COORD_W-1:0] req_b_min_x = '0, req_b_min_y = '0, req_b_min_z = '0;
   logic [COORD_W-1:0] req_b_max_x = '0, req_b_max_y = '0, req_b_max_z = '0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  rsp_valid;
   logic [ROOT_W-1:0]     rsp_box_gap;
   int                    errors;
   int                    outstanding;
   logic [MAX_AXES-1:0][PERIOD_W-1:0] period_now = '0;

   always #5 clock = ~clock;

   box_distance_periodic DUT (
      .clock, .reset, .start, .busy,
      .req_a_min_x, .req_a_min_y, .req_a_min_z,
      .req_a_max_x, .req_a_max_y, .req_a_max_z,
      .req_b_min_x, .req_b_min_y, .req_b_min_z,
      .req_b_max_x, .req_b_max_y, .req_b_max_z,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .rsp_valid, .rsp_box_gap
   );

   box_distance_periodic_monitor gap_monitor (
      .clock, .reset, .start, .busy,
      .req_a_min_x, .req_a_min_y, .req_a_min_z,
      .req_a_max_x, .req_a_max_y, .req_a_max_z,
      .req_b_min_x, .req_b_min_y, .req_b_min_z,
      .req_b_max_x, .req_b_max_y, .req_b_max_z,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .rsp_valid, .rsp_box_gap, .errors, .outstanding
   );

   // start stays high across back-to-back beats; only idle and drain lower it
   task automatic send_pair(corner_type alo, corner_type ahi, corner_type blo,
                            corner_type bhi);
      {req_a_min_z, req_a_min_y, req_a_min_x} <= alo;
      {req_a_max_z, req_a_max_y, req_a_max_x} <= ahi;
      {req_b_min_z, req_b_min_y, req_b_min_x} <= blo;
      {req_b_max_z, req_b_max_y, req_b_max_x} <= bhi;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic sender_idle(int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_PERIOD_X: period_now[0] = data[PERIOD_W-1:0];
         REG_PERIOD_Y: period_now[1] = data[PERIOD_W-1:0];
         REG_PERIOD_Z: period_now[2] = data[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_periods(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      write_reg(REG_PERIOD_X, px);
      write_reg(REG_PERIOD_Y, py);
      write_reg(REG_PERIOD_Z, pz);
      write_reg(REG_SPARE, $urandom);
      csr_valid <= 1'b0;
   endtask

   // signed value in [-2^s, 2^s)
   function automatic longint spread(int s);
      return longint'($signed($urandom)) >>> (31 - s);
   endfunction

   function automatic box_pair_type make_pair(pair_mode_type mode);
      box_pair_type p;
      longint       c, alo, ahi, blo, bhi, tmp;
      int           s, k;
      for (int i = 0; i < MAX_AXES; i++) begin
         if (mode == PAIR_NOISE) begin
            p.a_lo[i] = $urandom;
            p.a_hi[i] = $urandom;
            p.b_lo[i] = $urandom;
            p.b_hi[i] = $urandom;
         end else begin
            s   = $urandom_range(4, 30);
            c   = spread(s);
            alo = c;
            ahi = c + longint'($urandom_range(0, 32'd1 << s));
            blo = c + spread(s);
            bhi = blo + longint'($urandom_range(0, 32'd1 << s));
            if (mode == PAIR_PERIODIC) begin
               case ($urandom_range(3))
                  0: k = 1;
                  1: k = -1;
                  2: k = 2;
                  default: k = -2;
               endcase
               blo = blo + k * longint'(period_now[i]);
               bhi = bhi + k * longint'(period_now[i]);
            end
            if ($urandom_range(9) == 0) begin
               tmp = alo; alo = ahi; ahi = tmp;
            end
            if ($urandom_range(9) == 0) begin
               tmp = blo; blo = bhi; bhi = tmp;
            end
            p.a_lo[i] = alo[31:0];
            p.a_hi[i] = ahi[31:0];
            p.b_lo[i] = blo[31:0];
            p.b_hi[i] = bhi[31:0];
         end
      end
      return p;
   endfunction

   task automatic random_pairs(int count);
      box_pair_type  p;
      pair_mode_type mode;
      int            pct;
      int            r;
      for (int chunk = 0; chunk < 3; chunk++) begin
         pct = (chunk == 0) ? 0 : (chunk == 1) ? 82 : 20;
         repeat (count / 3) begin
            r    = $urandom_range(99);
            mode = (r < 15) ? PAIR_NOISE : (r < 55) ? PAIR_NEAR : PAIR_PERIODIC;
            p    = make_pair(mode);
            sender_idle(pct);
            send_pair(p.a_lo, p.a_hi, p.b_lo, p.b_hi);
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // periods at reset value: plain distance
      send_pair('0, '0, '0, '0);
      send_pair({3{CMIN}}, {3{CMIN}}, {3{CMAX}}, {3{CMAX}});
      send_pair({3{CMAX}}, {3{CMAX}}, {3{CMIN}}, {3{CMIN}});
      send_pair('0, {ONE, ONE, ONE}, {32'd0, 32'd0, 2 * ONE}, {ONE, ONE, 3 * ONE});
      send_pair({32'd0, 5 * ONE, 32'd0}, {ONE, 6 * ONE, ONE},
                {32'd0, -ONE, 32'd0}, {ONE, ONE, ONE});
      send_pair('0, {3{ONE}}, {3{ONE}}, {3{2 * ONE}});        // touching faces
      send_pair({3{3 * ONE}}, {3{-3 * ONE}}, {3{ONE}}, {3{2 * ONE}});  // A inverted
      send_pair('0, {3{ONE}}, {3{4 * ONE}}, {3{-4 * ONE}});   // B inverted
      send_pair({3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}, {3{32'h1}}, {3{CMAX}});
      send_pair('0, {3{32'd100}}, {3{32'd101}}, {3{32'd200}});  // one raw unit apart
      drain();

      program_periods(8 * ONE, 8 * ONE, 8 * ONE);
      send_pair('0, {3{ONE}}, {3{8 * ONE}}, {3{9 * ONE}});
      send_pair('0, {3{ONE}}, {3{-8 * ONE - HALF}}, {3{-7 * ONE - HALF}});
      send_pair('0, {3{ONE}}, {3{4 * ONE + HALF}}, {3{5 * ONE + HALF}});
      send_pair({3{CMIN}}, {3{CMIN}}, {3{CMAX}}, {3{CMAX}});
      drain();

      program_periods(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair({3{CMIN}}, {3{CMIN}}, {3{CMAX}}, {3{CMAX}});
      send_pair({3{CMAX}}, {3{CMAX}}, {3{CMIN}}, {3{CMIN}});
      send_pair('0, '0, {3{CMAX}}, {3{CMAX}});
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_periods(32'd0, 32'd0, 32'd0);
            1: program_periods(32'hFFFF_FFFF, CMAX, 32'hFFFF_FFFF);
            2: program_periods($urandom_range(1, 32'h00FF_FFFF),
                               $urandom_range(1, 32'h00FF_FFFF),
                               $urandom_range(1, 32'h00FF_FFFF));
            3: program_periods($urandom, $urandom, $urandom);
            4: program_periods(32'd0, CMAX, 32'd1);
            default: program_periods(CMIN | $urandom_range(1, 32'd1 << 20),
                                     CMIN | $urandom_range(1, 32'd1 << 20),
                                     CMIN | $urandom_range(1, 32'd1 << 20));
         endcase
         random_pairs(PHASE_ITEMS);
         drain();
      end

      if (errors == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/bdp_pkg.sv
rtl/core/bdp_axis_gap.sv
rtl/core/bdp_isqrt.sv
rtl/core/box_distance_periodic.sv
test/box_distance_periodic_monitor.sv
test/box_distance_periodic_tb.sv
